[hdl/assert_macros.svh]
// Shared assertion macros for the lock checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define KCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define KCL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/kcl_pkg.sv]
package kcl_pkg;

  localparam int unsigned CodeDigits = 4;
  localparam int unsigned DigitW     = $clog2(CodeDigits);
  localparam int unsigned KeyW       = 4;
  localparam int unsigned CodeW      = KeyW * CodeDigits;
  localparam int unsigned AddrW      = 3;

  localparam logic [KeyW-1:0] NoKey         = 4'd15;
  localparam logic [7:0]      EntryLimit    = 8'd48;
  localparam logic [7:0]      TryAgainStart = 8'd101;
  localparam logic [7:0]      TimeoutClear  = 8'd170;
  localparam logic [7:0]      LockoutStart  = 8'd4;
  localparam logic [7:0]      LockoutNotice = 8'd192;
  localparam logic [7:0]      LockoutEnd    = 8'd232;

  localparam logic [CodeW-1:0] CodeFirstRst  = 16'h1234;
  localparam logic [CodeW-1:0] CodeSecondRst = 16'h5678;

  typedef enum logic [3:0] {
    ST_ENTERING    = 4'd0,
    ST_UNLOCK      = 4'd1,
    ST_REJECT      = 4'd2,
    ST_LOCKED      = 4'd3,
    ST_NOTICE      = 4'd4,
    ST_LOCK_OVER   = 4'd5,
    ST_TIMED_OUT   = 4'd6,
    ST_TRY_AGAIN   = 4'd7,
    ST_TIMEOUT_CLR = 4'd8
  } status_e;

  typedef enum logic {
    REG_CODE_FIRST  = 1'b0,
    REG_CODE_SECOND = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic            go;
    logic [KeyW-1:0] key;
  } step_t;

  typedef struct packed {
    status_e           status;
    logic [DigitW-1:0] digits;
  } result_t;

endpackage

[hdl/kcl_core.sv]
module kcl_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kcl_pkg::step_t           step_i,
  input  logic [kcl_pkg::CodeW-1:0] code_first_i,
  input  logic [kcl_pkg::CodeW-1:0] code_second_i,
  output kcl_pkg::result_t         result_o
);
  import kcl_pkg::*;

  logic [7:0]        elapsed_q, elapsed_d;
  logic [DigitW-1:0] digit_q, digit_d;
  logic [7:0]        fail_q, fail_d;
  logic [KeyW-1:0]   entry_q [CodeDigits-1];
  logic              entry_we;
  logic [7:0]        elapsed_inc, elapsed_inc2, fail_inc;
  logic [CodeW-1:0]  cand;
  logic              match;
  status_e           status;

  always_comb begin
    cand = '0;
    for (int i = 0; i < CodeDigits - 1; i++) begin
      cand[KeyW*(CodeDigits-1-i) +: KeyW] = entry_q[i];
    end
    cand[KeyW-1:0] = step_i.key;
  end

  assign match        = (cand == code_first_i) || (cand == code_second_i);
  assign elapsed_inc  = elapsed_q + 8'd1;
  assign elapsed_inc2 = elapsed_q + 8'd2;
  assign fail_inc     = fail_q + 8'd1;

  always_comb begin
    elapsed_d = elapsed_q;
    digit_d   = digit_q;
    fail_d    = fail_q;
    status    = ST_ENTERING;
    entry_we  = 1'b0;
    if (step_i.go) begin
      elapsed_d = elapsed_inc;
      if (fail_q < LockoutStart && elapsed_inc < EntryLimit) begin
        if (step_i.key != NoKey) begin
          if (digit_q == DigitW'(CodeDigits - 1)) begin
            digit_d   = '0;
            elapsed_d = '0;
            if (match) begin
              status = ST_UNLOCK;
              fail_d = '0;
            end else begin
              status = ST_REJECT;
              fail_d = fail_inc;
            end
          end else begin
            entry_we = 1'b1;
            digit_d  = digit_q + 1'b1;
          end
        end
      end else if (fail_q >= LockoutStart) begin
        elapsed_d = '0;
        fail_d    = fail_inc;
        if (fail_inc == LockoutNotice) begin
          status = ST_NOTICE;
        end else if (fail_inc == LockoutEnd) begin
          status = ST_LOCK_OVER;
          fail_d = '0;
        end else begin
          status = ST_LOCKED;
        end
      end else if (elapsed_inc < TryAgainStart) begin
        status    = ST_TIMED_OUT;
        elapsed_d = elapsed_inc2;
      end else if (elapsed_inc < TimeoutClear) begin
        status    = ST_TRY_AGAIN;
        elapsed_d = elapsed_inc2;
      end else begin
        status    = ST_TIMEOUT_CLR;
        elapsed_d = '0;
        digit_d   = '0;
      end
    end
  end

  assign result_o.status = status;
  assign result_o.digits = digit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      digit_q   <= '0;
      fail_q    <= '0;
    end else begin
      elapsed_q <= elapsed_d;
      digit_q   <= digit_d;
      fail_q    <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_q[digit_q] <= step_i.key;
    end
  end

endmodule

[hdl/keypad_code_lock_with_lockout_top.sv]
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; the input and result registers each
// take a new request whenever the result ahead of them moves on.
// Reset (rst_ni low, asynchronous): counters clear, codes return to 1234 and
// 5678, both channels empty; the stored code digits keep no reset value.
module keypad_code_lock_with_lockout_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kcl_pkg::KeyW-1:0]    key_code_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [3:0]                  status_o,
  output logic [kcl_pkg::DigitW-1:0]  digits_entered_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kcl_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import kcl_pkg::*;

  logic              in_valid_q;
  logic [KeyW-1:0]   key_q;
  logic              out_valid_q;
  status_e           status_q;
  logic [DigitW-1:0] digits_q;
  logic [CodeW-1:0]  code_first_q, code_second_q;
  logic              advance;
  logic              cfg_wr;
  reg_idx_e          reg_idx;
  step_t             step;
  result_t           result;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign step.go    = in_valid_q && advance;
  assign step.key   = key_q;

  kcl_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .code_first_i  (code_first_q),
    .code_second_i (code_second_q),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      key_q <= key_code_i;
    end
    if (step.go) begin
      status_q <= result.status;
      digits_q <= result.digits;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign digits_entered_o = digits_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_first_q  <= CodeFirstRst;
      code_second_q <= CodeSecondRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CODE_FIRST:  code_first_q  <= pwdata[CodeW-1:0];
        REG_CODE_SECOND: code_second_q <= pwdata[CodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CODE_FIRST:  prdata = {{(32-CodeW){1'b0}}, code_first_q};
      REG_CODE_SECOND: prdata = {{(32-CodeW){1'b0}}, code_second_q};
      default:         prdata = '0;
    endcase
  end

endmodule

[hdl/kcl_checker.sv]
`include "assert_macros.svh"

module kcl_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [3:0]                 status_o,
  input logic [kcl_pkg::DigitW-1:0] digits_entered_o
);
  import kcl_pkg::*;

  `KCL_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(digits_entered_o), "result changed while stalled")
  `KCL_ASSERT(a_status_range, out_valid_o |-> status_o <= ST_TIMEOUT_CLR, "status code out of range")
  `KCL_ASSERT(a_digits_clear, out_valid_o && (status_o == ST_UNLOCK || status_o == ST_REJECT || status_o == ST_LOCKED || status_o == ST_NOTICE || status_o == ST_LOCK_OVER || status_o == ST_TIMEOUT_CLR) |-> digits_entered_o == '0, "digit count not cleared")
  `KCL_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind keypad_code_lock_with_lockout_top kcl_checker u_kcl_checker (.*);
